// ===== hw/rtl/multichannel_watchdog_supervisor_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the watchdog supervisor
// Checks are compiled in simulation and left out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_WATCHDOG_SUPERVISOR_DEFINES_SVH
`define MULTICHANNEL_WATCHDOG_SUPERVISOR_DEFINES_SVH
`ifndef SYNTH
`define MWS_ASSERT_NOW(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);
`define MWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MWS_ASSERT_NOW(lbl, expr, msg)
`define MWS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/mws_pkg.sv =====
// ----------------------------------------------------------------------------
// Watchdog supervisor package
// Command codes, result codes and the structs shared by the cells and top.
// ----------------------------------------------------------------------------
package mws_pkg;

    typedef enum logic [2:0] {
        CMD_REGISTER   = 3'd0,
        CMD_UNREGISTER = 3'd1,
        CMD_START      = 3'd2,
        CMD_STOP       = 3'd3,
        CMD_RESTART    = 3'd4,
        CMD_KICK       = 3'd5,
        CMD_TICK       = 3'd6
    } cmd_e;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECT   = 2'd1;
    localparam logic [1:0] ST_SPAWN_NG = 2'd2;

    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_RESTARTED = 2'd1;
    localparam logic [1:0] EV_FAILED    = 2'd2;
    localparam logic [1:0] EV_GAVE_UP   = 2'd3;

    localparam logic [7:0] UNLIMITED_RETRIES = 8'd255;
    localparam int         MAX_RESULTS       = 8;

    typedef struct packed {
        logic        cmd_en;
        logic [2:0]  cmd;
        logic [31:0] now;
        logic [31:0] tmo;
        logic [7:0]  lim;
        logic        wd;
        logic        ok;
    } cell_ctl_t;

    typedef struct packed {
        logic       used;
        logic       run;
        logic [7:0] rc;
    } cell_stat_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] ch;
        logic [1:0] ev;
        logic [7:0] rc;
    } cell_evt_t;

endpackage

// ===== hw/rtl/mws_cell.sv =====
// ----------------------------------------------------------------------------
// Watchdog supervisor channel cell
// Holds one channel's state, applies addressed commands and checks its
// watchdog when the scan token passes through it.
// ----------------------------------------------------------------------------
module mws_cell
    import mws_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctl_t  ctl,
    input  logic       hit,
    input  logic       adv,
    input  logic       tok_in,
    output logic       tok_out,
    output cell_stat_t stat,
    output cell_evt_t  evt
);

    localparam logic [2:0] CH = 3'(IDX);

    logic        used_reg, run_reg, sup_reg, tok_reg;
    logic [31:0] hb_reg, tmo_reg;
    logic [7:0]  rc_reg, lim_reg;
    logic [31:0] elapsed;
    logic        expire, retry_ok, proc, respawn;
    logic [7:0]  rc_inc;
    logic [1:0]  ev;
    logic        cmd_hit;

    assign elapsed  = ctl.now - hb_reg;
    assign expire   = used_reg && run_reg && sup_reg && (elapsed > tmo_reg);
    assign retry_ok = (rc_reg < lim_reg) || (lim_reg == UNLIMITED_RETRIES);
    assign proc     = adv && tok_reg && expire;
    assign respawn  = retry_ok && ctl.ok;
    assign rc_inc   = rc_reg + {7'd0, (rc_reg != 8'd255)};
    assign cmd_hit  = ctl.cmd_en && hit;

    always_comb begin
        if (!retry_ok) begin
            ev = EV_GAVE_UP;
        end else if (ctl.ok) begin
            ev = EV_RESTARTED;
        end else begin
            ev = EV_FAILED;
        end
    end

    assign tok_out   = tok_reg;
    assign stat.used = used_reg;
    assign stat.run  = run_reg;
    assign stat.rc   = rc_reg;
    assign evt.valid = tok_reg && expire;
    assign evt.ch    = (tok_reg && expire) ? CH : 3'd0;
    assign evt.ev    = (tok_reg && expire) ? ev : EV_NONE;
    assign evt.rc    = (tok_reg && expire) ? (respawn ? rc_inc : rc_reg) : 8'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
            run_reg  <= 1'b0;
            sup_reg  <= 1'b0;
            tok_reg  <= 1'b0;
        end else begin
            if (adv) begin
                tok_reg <= tok_in;
            end
            if (proc) begin
                run_reg <= respawn;
            end else if (cmd_hit) begin
                unique case (ctl.cmd)
                    CMD_REGISTER: begin
                        if (!used_reg) begin
                            used_reg <= 1'b1;
                            run_reg  <= 1'b0;
                            sup_reg  <= ctl.wd;
                        end
                    end
                    CMD_UNREGISTER: begin
                        used_reg <= 1'b0;
                        run_reg  <= 1'b0;
                    end
                    CMD_START: begin
                        if (used_reg && ctl.ok) begin
                            run_reg <= 1'b1;
                        end
                    end
                    CMD_STOP: begin
                        run_reg <= 1'b0;
                    end
                    CMD_RESTART: begin
                        if (used_reg) begin
                            run_reg <= ctl.ok;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            if (respawn) begin
                hb_reg <= ctl.now;
                rc_reg <= rc_inc;
            end
        end else if (cmd_hit) begin
            unique case (ctl.cmd)
                CMD_REGISTER: begin
                    if (!used_reg) begin
                        hb_reg  <= 32'd0;
                        rc_reg  <= 8'd0;
                        tmo_reg <= ctl.tmo;
                        lim_reg <= ctl.lim;
                    end
                end
                CMD_START: begin
                    if (used_reg && !run_reg && ctl.ok) begin
                        hb_reg <= ctl.now;
                        rc_reg <= 8'd0;
                    end
                end
                CMD_RESTART: begin
                    if (used_reg && ctl.ok) begin
                        hb_reg <= ctl.now;
                        rc_reg <= 8'd0;
                    end
                end
                CMD_KICK: begin
                    if (used_reg && run_reg) begin
                        hb_reg <= ctl.now;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/multichannel_watchdog_supervisor.sv =====
// ----------------------------------------------------------------------------
// Multichannel watchdog supervisor
// A row of channel cells with a scan token and a one-word result register.
// ----------------------------------------------------------------------------
// Input words carry a command for one channel slot or a tick. A channel
// command gives one result word with tlast set, registered in the cycle
// after acceptance. A tick sends a token down the row of cells, one cell
// per cycle while the output register is free; each cell checks its
// watchdog as the token passes. One timed-out channel result is held
// back so that the final one can carry tlast, and the next input word is
// taken only after the final result word has been loaded.
// At most eight event words are sent per tick; a tick without events gives
// one empty word with tlast set.
// When the receiver stalls, the token halts in place and no further word
// is accepted until the results are delivered.
// Reset clears every slot to unused and stopped; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "multichannel_watchdog_supervisor_defines.svh"

module multichannel_watchdog_supervisor
    import mws_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd, channel, now, timeout, retry limit, watchdog enable, spawn ok
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, event_channel, event_res, retries_done, zero pad
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

    localparam int NW = $clog2(MAX_RESULTS + 1);

    state_t      state_reg;
    logic        m_valid_reg, m_last_reg;
    logic [1:0]  m_st_reg, m_ev_reg;
    logic [2:0]  m_ch_reg;
    logic [7:0]  m_rc_reg;
    cell_evt_t   hold_reg;
    logic [NW-1:0] n_reg;
    logic [31:0] now_reg;
    logic        ok_reg;

    logic [2:0]  in_cmd, in_ch;
    logic [31:0] in_now, in_tmo;
    logic [7:0]  in_lim;
    logic        in_wd, in_ok;
    logic        out_free, accept, start, adv, in_range;
    cell_ctl_t   ctl;
    logic [CHANNELS-1:0] hit, tok;
    cell_stat_t  stat [CHANNELS];
    cell_evt_t   evt  [CHANNELS];
    cell_evt_t   evt_any;
    cell_stat_t  sel;
    logic [1:0]  cmd_st;
    logic [7:0]  cmd_rc;
    logic        report;
    logic        m_load;

    assign in_cmd = s_axis_tdata[2:0];
    assign in_ch  = s_axis_tdata[5:3];
    assign in_now = s_axis_tdata[37:6];
    assign in_tmo = s_axis_tdata[69:38];
    assign in_lim = s_axis_tdata[77:70];
    assign in_wd  = s_axis_tdata[78];
    assign in_ok  = s_axis_tdata[79];

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign start         = accept && (in_cmd == CMD_TICK);
    assign adv           = start || ((state_reg == S_SCAN) && out_free);
    assign in_range      = int'(in_ch) < CHANNELS;

    assign ctl.cmd_en = accept && (in_cmd != CMD_TICK) && in_range;
    assign ctl.cmd    = in_cmd;
    assign ctl.now    = (state_reg == S_IDLE) ? in_now : now_reg;
    assign ctl.tmo    = in_tmo;
    assign ctl.lim    = in_lim;
    assign ctl.wd     = in_wd;
    assign ctl.ok     = (state_reg == S_IDLE) ? in_ok : ok_reg;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
        assign hit[i] = (int'(in_ch) == i);
        mws_cell #(.IDX(i)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .hit     (hit[i]),
            .adv     (adv),
            .tok_in  ((i == 0) ? start : tok[(i == 0) ? 0 : i-1]),
            .tok_out (tok[i]),
            .stat    (stat[i]),
            .evt     (evt[i])
        );
    end

    always_comb begin
        evt_any = '0;
        sel     = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            evt_any = evt_any | evt[i];
            if (hit[i]) begin
                sel = stat[i];
            end
        end
        if (!in_range) begin
            sel = '0;
        end
    end

    // Status and retry count of a channel command, as seen after the step.
    always_comb begin
        cmd_st = ST_REJECT;
        cmd_rc = sel.used ? sel.rc : 8'd0;
        if (in_range) begin
            unique case (in_cmd)
                CMD_REGISTER: begin
                    if (!sel.used) begin
                        cmd_st = ST_OK;
                        cmd_rc = 8'd0;
                    end
                end
                CMD_UNREGISTER: begin
                    if (sel.used) begin
                        cmd_st = ST_OK;
                    end
                    cmd_rc = 8'd0;
                end
                CMD_START: begin
                    if (sel.used && !sel.run) begin
                        cmd_st = in_ok ? ST_OK : ST_SPAWN_NG;
                        if (in_ok) begin
                            cmd_rc = 8'd0;
                        end
                    end
                end
                CMD_STOP: begin
                    if (sel.used && sel.run) begin
                        cmd_st = ST_OK;
                    end
                end
                CMD_RESTART: begin
                    if (sel.used) begin
                        cmd_st = in_ok ? ST_OK : ST_SPAWN_NG;
                        if (in_ok) begin
                            cmd_rc = 8'd0;
                        end
                    end
                end
                CMD_KICK: begin
                    if (sel.used && sel.run) begin
                        cmd_st = ST_OK;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign report = evt_any.valid && (int'(n_reg) < MAX_RESULTS);

    // A new result word enters the output register in this cycle.
    assign m_load = (accept && !start)
                 || ((state_reg == S_SCAN) && out_free && report && hold_reg.valid)
                 || ((state_reg == S_FINISH) && out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            n_reg       <= '0;
            hold_reg    <= '0;
        end else begin
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        state_reg      <= S_SCAN;
                        n_reg          <= '0;
                        hold_reg.valid <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (out_free) begin
                        if (report) begin
                            hold_reg <= evt_any;
                            n_reg    <= n_reg + NW'(1);
                        end
                        if (tok[CHANNELS-1]) begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            now_reg <= in_now;
            ok_reg  <= in_ok;
        end
        if (accept && !start) begin
            m_st_reg   <= cmd_st;
            m_ch_reg   <= in_ch;
            m_ev_reg   <= EV_NONE;
            m_rc_reg   <= cmd_rc;
            m_last_reg <= 1'b1;
        end else if ((state_reg == S_SCAN) && out_free && report && hold_reg.valid) begin
            m_st_reg   <= ST_OK;
            m_ch_reg   <= hold_reg.ch;
            m_ev_reg   <= hold_reg.ev;
            m_rc_reg   <= hold_reg.rc;
            m_last_reg <= 1'b0;
        end else if ((state_reg == S_FINISH) && out_free) begin
            m_st_reg   <= ST_OK;
            m_ch_reg   <= hold_reg.valid ? hold_reg.ch : 3'd0;
            m_ev_reg   <= hold_reg.valid ? hold_reg.ev : EV_NONE;
            m_rc_reg   <= hold_reg.valid ? hold_reg.rc : 8'd0;
            m_last_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_rc_reg, m_ev_reg, m_ch_reg, m_st_reg};
    assign m_axis_tlast  = m_last_reg;

    `MWS_ASSERT_NOW(a_tok_onehot, $onehot0(tok), "more than one scan token in the row")
    `MWS_ASSERT_NOW(a_idle_no_tok, (state_reg != S_IDLE) || (tok == '0),
        "scan token present while idle")
    `MWS_ASSERT_NEXT(a_cmd_result, accept && (in_cmd != CMD_TICK),
        m_axis_tvalid && m_axis_tlast, "channel command gave no result word")
    `MWS_ASSERT_NOW(a_count_cap, int'(n_reg) <= MAX_RESULTS, "event count overran")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Watchdog supervisor testbench
// Drives command and tick words into the supervisor, predicts every result
// word from a behavioral copy of the channel table and checks the results
// in order, with random idle bursts on both sides of the stream.
// ----------------------------------------------------------------------------
module tb;
    import mws_pkg::*;

    localparam int          NCH       = 8;
    localparam logic [2:0]  CMD_UNDEF = 3'd7;
    localparam int          TICK_LAT  = NCH + 4;
    localparam int          STALL_MAX = 3000;

    typedef struct {
        logic [2:0]  cmd;
        logic [2:0]  ch;
        logic [31:0] now;
        logic [31:0] tmo;
        logic [7:0]  lim;
        logic        wd;
        logic        ok;
        bit          drain;
    } cmd_word_t;

    typedef struct {
        logic [1:0] status;
        logic [2:0] ch;
        logic [1:0] ev;
        logic [7:0] rd;
        logic       last;
    } event_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    multichannel_watchdog_supervisor #(.CHANNELS(NCH)) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Shadow copy of the channel table.
    bit          sh_used [NCH];
    bit          sh_run  [NCH];
    bit          sh_wd   [NCH];
    logic [31:0] sh_beat [NCH];
    logic [31:0] sh_tmo  [NCH];
    logic [7:0]  sh_rc   [NCH];
    logic [7:0]  sh_lim  [NCH];

    cmd_word_t   cmd_queue[$];
    event_word_t pending_events[$];
    cmd_word_t   cur_word;
    int          errors    = 0;
    int          accepted  = 0;
    int          idle_cyc  = 0;
    int          gap       = 0;
    int          drain_cnt = 0;
    int          hold_cnt  = 0;
    int          rx_gap    = 0;
    bit          hold_done = 0;
    bit          calm      = 0;
    bit          taken     = 0;
    logic [31:0] clock_ms  = 0;

    function automatic event_word_t mk_event(logic [1:0] st, logic [2:0] ch,
                                             logic [1:0] ev, logic [7:0] rd,
                                             logic lst);
        event_word_t e;
        e.status = st;
        e.ch     = ch;
        e.ev     = ev;
        e.rd     = rd;
        e.last   = lst;
        return e;
    endfunction

    task automatic scan_watchdogs(cmd_word_t w);
        int          n;
        logic [1:0]  ev;
        n = 0;
        for (int i = 0; i < NCH; i++) begin
            if (!sh_used[i] || !sh_run[i] || !sh_wd[i]) continue;
            if (w.now - sh_beat[i] <= sh_tmo[i]) continue;
            sh_run[i] = 0;
            if (sh_rc[i] < sh_lim[i] || sh_lim[i] == UNLIMITED_RETRIES) begin
                if (w.ok) begin
                    sh_beat[i] = w.now;
                    sh_run[i]  = 1;
                    if (sh_rc[i] != 8'hFF) sh_rc[i]++;
                    ev = EV_RESTARTED;
                end else begin
                    ev = EV_FAILED;
                end
            end else begin
                ev = EV_GAVE_UP;
            end
            if (n < MAX_RESULTS) begin
                pending_events.push_back(mk_event(ST_OK, 3'(i), ev, sh_rc[i], 1'b0));
                n++;
            end
        end
        if (n == 0) pending_events.push_back(mk_event(ST_OK, 3'd0, EV_NONE, 8'd0, 1'b1));
        else pending_events[$].last = 1'b1;
    endtask

    task automatic apply_command(cmd_word_t w);
        logic [1:0] st;
        int         c;
        st = ST_REJECT;
        c  = w.ch;
        if (w.cmd == CMD_TICK) begin
            scan_watchdogs(w);
            return;
        end
        case (w.cmd)
            CMD_REGISTER: if (!sh_used[c]) begin
                sh_used[c] = 1;
                sh_run[c]  = 0;
                sh_beat[c] = 0;
                sh_rc[c]   = 0;
                sh_tmo[c]  = w.tmo;
                sh_lim[c]  = w.lim;
                sh_wd[c]   = w.wd;
                st = ST_OK;
            end
            CMD_UNREGISTER: if (sh_used[c]) begin
                sh_used[c] = 0;
                sh_run[c]  = 0;
                st = ST_OK;
            end
            CMD_START: if (sh_used[c] && !sh_run[c]) begin
                if (w.ok) begin
                    sh_beat[c] = w.now;
                    sh_run[c]  = 1;
                    sh_rc[c]   = 0;
                    st = ST_OK;
                end else begin
                    st = ST_SPAWN_NG;
                end
            end
            CMD_STOP: if (sh_used[c] && sh_run[c]) begin
                sh_run[c] = 0;
                st = ST_OK;
            end
            CMD_RESTART: if (sh_used[c]) begin
                sh_run[c] = 0;
                if (w.ok) begin
                    sh_beat[c] = w.now;
                    sh_run[c]  = 1;
                    sh_rc[c]   = 0;
                    st = ST_OK;
                end else begin
                    st = ST_SPAWN_NG;
                end
            end
            CMD_KICK: if (sh_used[c] && sh_run[c]) begin
                sh_beat[c] = w.now;
                st = ST_OK;
            end
            default: ;
        endcase
        pending_events.push_back(mk_event(st, w.ch, EV_NONE,
                                          sh_used[c] ? sh_rc[c] : 8'd0, 1'b1));
    endtask

    function automatic cmd_word_t mk_word(logic [2:0] cmd, logic [2:0] ch,
                                          logic [31:0] now, logic [31:0] tmo,
                                          logic [7:0] lim, logic wd, logic ok);
        cmd_word_t w;
        w.cmd   = cmd;
        w.ch    = ch;
        w.now   = now;
        w.tmo   = tmo;
        w.lim   = lim;
        w.wd    = wd;
        w.ok    = ok;
        w.drain = 0;
        return w;
    endfunction

    function automatic cmd_word_t random_word();
        int          pick;
        logic [2:0]  cmd;
        logic [31:0] tmo;
        logic [7:0]  lim;
        pick = $urandom_range(0, 99);
        if (pick < 30)      cmd = CMD_TICK;
        else if (pick < 42) cmd = CMD_REGISTER;
        else if (pick < 48) cmd = CMD_UNREGISTER;
        else if (pick < 62) cmd = CMD_START;
        else if (pick < 72) cmd = CMD_RESTART;
        else if (pick < 78) cmd = CMD_STOP;
        else if (pick < 97) cmd = CMD_KICK;
        else                cmd = CMD_UNDEF;
        if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 30);
        tmo = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 40);
        pick = $urandom_range(0, 9);
        lim = (pick < 6) ? 8'($urandom_range(0, 3)) : (pick < 8) ? 8'hFF : 8'($urandom);
        return mk_word(cmd, 3'($urandom), clock_ms, tmo, lim,
                       $urandom_range(0, 5) != 0, $urandom_range(0, 5) != 0);
    endfunction

    // Sender: one word is held on the bus until accepted.
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            apply_command(cur_word);
            accepted <= accepted + 1;
            taken = 1;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || taken) begin
            if (taken && !calm && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 5);
            taken = 0;
            if (gap > 0) begin
                gap--;
                s_axis_tvalid <= 1'b0;
            end else if (cmd_queue.size() != 0 && cmd_queue[0].drain) begin
                s_axis_tvalid <= 1'b0;
                if (pending_events.size() != 0 || s_axis_tvalid) begin
                    drain_cnt = TICK_LAT;
                end else if (drain_cnt > 0) begin
                    drain_cnt--;
                end else begin
                    void'(cmd_queue.pop_front());
                end
            end else if (cmd_queue.size() != 0) begin
                cur_word = cmd_queue.pop_front();
                s_axis_tdata <= {cur_word.ok, cur_word.wd, cur_word.lim, cur_word.tmo,
                                 cur_word.now, cur_word.ch, cur_word.cmd};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, and one long hold-off to back the block up.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && accepted >= 100) begin
            hold_done = 1;
            hold_cnt  = 150;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            if (!calm && $urandom_range(0, 4) == 0) rx_gap = $urandom_range(1, 5);
            m_axis_tready <= (rx_gap == 0);
        end
    end

    always @(posedge aclk) begin
        event_word_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result word, actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                want = pending_events.pop_front();
                if (m_axis_tdata[1:0] !== want.status || m_axis_tdata[4:2] !== want.ch ||
                    m_axis_tdata[6:5] !== want.ev || m_axis_tdata[14:7] !== want.rd ||
                    m_axis_tlast !== want.last) begin
                    $display("%0t: mismatch, expected st %0d ch %0d ev %0d rd %0d last %b",
                             $time, want.status, want.ch, want.ev, want.rd, want.last);
                    $display("%0t:           actual st %0d ch %0d ev %0d rd %0d last %b",
                             $time, m_axis_tdata[1:0], m_axis_tdata[4:2],
                             m_axis_tdata[6:5], m_axis_tdata[14:7], m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc > STALL_MAX) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        cmd_word_t w;
        for (int i = 0; i < NCH; i++) begin
            sh_used[i] = 0; sh_run[i] = 0; sh_wd[i] = 0;
            sh_beat[i] = 0; sh_tmo[i] = 0; sh_rc[i] = 0; sh_lim[i] = 0;
        end
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;

        // Directed part: limits of the fields, every command, spawn failures,
        // time wraparound, retry limit reached and an undefined command.
        cmd_queue.push_back(mk_word(CMD_REGISTER, 0, 0, 0, 0, 1, 1));
        cmd_queue.push_back(mk_word(CMD_REGISTER, 0, 0, 5, 3, 1, 1));
        cmd_queue.push_back(mk_word(CMD_REGISTER, 7, '1, '1, 8'hFF, 1, 1));
        cmd_queue.push_back(mk_word(CMD_REGISTER, 1, 0, 5, 1, 0, 0));
        cmd_queue.push_back(mk_word(CMD_REGISTER, 2, 0, 0, 3, 1, 1));
        cmd_queue.push_back(mk_word(CMD_START, 0, 32'hFFFF_FFF0, 0, 0, 0, 0));
        cmd_queue.push_back(mk_word(CMD_START, 0, 32'hFFFF_FFF0, 0, 0, 0, 1));
        cmd_queue.push_back(mk_word(CMD_START, 0, 0, 0, 0, 0, 1));
        cmd_queue.push_back(mk_word(CMD_KICK, 0, 5, 0, 0, 0, 1));
        cmd_queue.push_back(mk_word(CMD_KICK, 3, 5, 0, 0, 0, 1));
        cmd_queue.push_back(mk_word(CMD_STOP, 1, 5, 0, 0, 0, 1));
        cmd_queue.push_back(mk_word(CMD_START, 7, 0, 0, 0, 0, 1));
        cmd_queue.push_back(mk_word(CMD_START, 2, 0, 0, 0, 0, 1));
        cmd_queue.push_back(mk_word(CMD_RESTART, 1, 6, 0, 0, 0, 1));
        cmd_queue.push_back(mk_word(CMD_RESTART, 3, 6, 0, 0, 0, 1));
        cmd_queue.push_back(mk_word(CMD_TICK, 5, 10, '1, 8'hFF, 1, 0));
        cmd_queue.push_back(mk_word(CMD_TICK, 0, 20, 0, 0, 0, 1));
        cmd_queue.push_back(mk_word(CMD_TICK, 0, 20, 0, 0, 0, 1));
        cmd_queue.push_back(mk_word(CMD_UNDEF, 7, 20, 0, 0, 0, 1));
        cmd_queue.push_back(mk_word(CMD_STOP, 1, 20, 0, 0, 0, 1));
        cmd_queue.push_back(mk_word(CMD_UNREGISTER, 1, 20, 0, 0, 0, 1));
        cmd_queue.push_back(mk_word(CMD_UNREGISTER, 1, 20, 0, 0, 0, 1));
        cmd_queue.push_back(mk_word(CMD_RESTART, 0, 20, 0, 0, 0, 0));
        cmd_queue.push_back(mk_word(CMD_RESTART, 0, 20, 0, 0, 0, 1));

        clock_ms = 20;
        for (int n = 0; n < 40; n++) begin
            if (n == 25) begin
                w = mk_word(CMD_TICK, 0, 0, 0, 0, 0, 0);
                w.drain = 1;
                cmd_queue.push_back(w);
            end
            cmd_queue.push_back(random_word());
        end

        // An unlimited channel that times out on every tick drives its
        // retry count into saturation.
        cmd_queue.push_back(mk_word(CMD_UNREGISTER, 5, clock_ms, 0, 0, 0, 1));
        cmd_queue.push_back(mk_word(CMD_REGISTER, 5, clock_ms, 0, 8'hFF, 1, 1));
        cmd_queue.push_back(mk_word(CMD_RESTART, 5, clock_ms, 0, 0, 0, 1));
        for (int n = 0; n < 256; n++) begin
            clock_ms++;
            cmd_queue.push_back(mk_word(CMD_TICK, 0, clock_ms, 0, 0, 0, 1));
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_queue.size() > 40) @(posedge aclk);
        calm = 1;
        while (cmd_queue.size() != 0 || s_axis_tvalid) @(posedge aclk);
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (TICK_LAT + 10) @(posedge aclk);

        if (errors == 0 && pending_events.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
